[hdl/tsbm_pkg.sv]
package tsbm_pkg;

  // default coordinate width (signed fixed point, 16 fraction bits)
  localparam int COORD_BITS_DEF = 32;

  // configuration register file
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SLOP_MARGIN = 2'd0,
    REG_COINCIDE    = 2'd1
  } cfg_reg_e;

  localparam logic [CFG_BITS-1:0] SLOP_RESET   = 16'd33;
  localparam logic [CFG_BITS-1:0] THRESH_RESET = 16'd1;

endpackage

[hdl/tsbm_sqrt.sv]
module tsbm_sqrt #(
  parameter int RW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root
);

  // one result bit per stage, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int I = RW - 1 - k;
    logic [2*RW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW:0]   trial;
    logic [2*RW-1:0] rem_q;
    logic [RW-1:0]   root_q;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = g_stage[k-1].rem_q;
      assign root_in = g_stage[k-1].root_q;
    end

    // (2r + 2^i) * 2^i, root bits sit above i so the parts do not overlap
    assign trial = ({{(RW+1){1'b0}}, root_in} << (I + 1)) | ((2*RW+1)'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q  <= rem_in - trial[2*RW-1:0];
          root_q <= root_in | (RW'(1) << I);
        end else begin
          rem_q  <= rem_in;
          root_q <= root_in;
        end
      end
    end
  end

  assign root = g_stage[RW-1].root_q;

endmodule

[hdl/tsbm_div.sv]
module tsbm_div #(
  parameter int DW = 34,
  parameter int QW = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] numer,
  input  logic [DW-1:0]    denom,
  output logic [QW-1:0]    quot
);

  localparam int XW = DW + QW;

  // restoring division, one quotient bit per stage; quotient known below 2^QW
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [XW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic [XW-1:0] trial;
    logic [XW-1:0] rem_q;
    logic [DW-1:0] denom_q;
    logic [QW-1:0] quot_q;

    if (k == 0) begin : g_first
      assign rem_in  = numer;
      assign den_in  = denom;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = g_stage[k-1].rem_q;
      assign den_in  = g_stage[k-1].denom_q;
      assign quot_in = g_stage[k-1].quot_q;
    end

    assign trial = XW'(den_in) << I;

    always_ff @(posedge clk) begin
      if (en) begin
        denom_q <= den_in;
        if (rem_in >= trial) begin
          rem_q  <= rem_in - trial;
          quot_q <= quot_in | (QW'(1) << I);
        end else begin
          rem_q  <= rem_in;
          quot_q <= quot_in;
        end
      end
    end
  end

  assign quot = g_stage[QW-1].quot_q;

endmodule

[hdl/two_sphere_bounding_merge.sv]
// throughput: one sphere pair per cycle while the output is not stalled; the
//   square root and the three axis dividers are pipelined one bit per stage
// the whole pipeline holds while a result waits at a stalled output
// reset: synchronous, clears valid bits and loads slop 33, threshold 1
module two_sphere_bounding_merge #(
  parameter int COORD_BITS = tsbm_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsbm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tsbm_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     first_center_x,
  input  logic signed [COORD_BITS-1:0]     first_center_y,
  input  logic signed [COORD_BITS-1:0]     first_center_z,
  input  logic [COORD_BITS-2:0]            first_radius,
  input  logic signed [COORD_BITS-1:0]     second_center_x,
  input  logic signed [COORD_BITS-1:0]     second_center_y,
  input  logic signed [COORD_BITS-1:0]     second_center_z,
  input  logic [COORD_BITS-2:0]            second_radius,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS-1:0]     out_center_x,
  output logic signed [COORD_BITS-1:0]     out_center_y,
  output logic signed [COORD_BITS-1:0]     out_center_z,
  output logic [COORD_BITS-2:0]            out_radius,
  output logic                             coincident,
  output logic                             saturated
);
  import tsbm_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;        // magnitude of a center difference
  localparam int RW = C + 1;        // center distance
  localparam int SW = 2 * RW;       // sum of squares
  localparam int EW = C + 3;        // signed extents along the line
  localparam int EM = C + 2;        // magnitude of the extent sum
  localparam int H  = EM / 2;
  localparam int HH = EM - H;
  localparam int QW = C + 1;        // axis offset quotient
  localparam int VW = RW + 1;       // divisor 2*distance
  localparam int NW = VW + QW;      // dividend
  localparam int OW = C + 3;        // center plus offset

  localparam logic signed [EW-1:0] RAD_MAX = EW'((64'd1 << (C - 1)) - 64'd1);
  localparam logic signed [OW-1:0] CRD_MAX = OW'((64'd1 << (C - 1)) - 64'd1);
  localparam logic signed [OW-1:0] CRD_MIN = -CRD_MAX - OW'(1);

  typedef struct packed {
    logic signed [2:0][C-1:0] c1;
    logic [2:0][DW-1:0]       dmag;
    logic [2:0]               dneg;
    logic [C-2:0]             r1;
    logic [C-2:0]             r2;
  } early_t;

  typedef struct packed {
    logic signed [2:0][C-1:0] c1;
    logic [2:0]               neg;
    logic                     kill;
    logic                     coin;
    logic [C-2:0]             rad;
    logic                     rad_sat;
  } late_t;

  // configuration registers
  logic [CFG_BITS-1:0] slop;
  logic [CFG_BITS-1:0] thresh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slop   <= SLOP_RESET;
      thresh <= THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLOP_MARGIN: slop   <= cfg_data;
        REG_COINCIDE:    thresh <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result waits at the output
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic signed [2:0][C-1:0] ca, cb;
  early_t e_in, s1, s2, s3;
  logic s1_v, s2_v, s3_v;

  assign ca = {first_center_z, first_center_y, first_center_x};
  assign cb = {second_center_z, second_center_y, second_center_x};

  always_comb begin
    logic signed [C:0] d;
    e_in.c1 = ca;
    e_in.r1 = first_radius;
    e_in.r2 = second_radius;
    for (int a = 0; a < 3; a++) begin
      d = {cb[a][C-1], cb[a]} - {ca[a][C-1], ca[a]};
      e_in.dneg[a] = d[C];
      e_in.dmag[a] = d[C] ? DW'(-d) : DW'(d);
    end
  end

  // stage 2: squares, stage 3: sum
  logic [2:0][SW-1:0] sq;
  logic [SW-1:0]      sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= e_in;
      s2 <= s1;
      s3 <= s2;
      for (int a = 0; a < 3; a++) begin
        sq[a] <= SW'(s1.dmag[a] * s1.dmag[a]);
      end
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  // square root, sideband delayed alongside
  logic [RW-1:0] ctr_dist;
  early_t        sq_side [RW];
  logic [RW-1:0] sq_v;

  tsbm_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .root     (ctr_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (en) begin
      sq_v <= {sq_v[RW-2:0], s3_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= s3;
      for (int k = 1; k < RW; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // stage 4: coincidence test and extents of the second sphere
  early_t              s4;
  logic                s4_v, s4_coin, s4_zero;
  logic [RW-1:0]       s4_dist;
  logic signed [EW-1:0] s4_lo2, s4_hi2, s4_r1, s4_crad;

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] ds, r1s, r2s, sls, b;
    if (en) begin
      ds   = $signed({2'b00, ctr_dist});
      r1s  = $signed({4'b0000, sq_side[RW-1].r1});
      r2s  = $signed({4'b0000, sq_side[RW-1].r2});
      sls  = $signed({{(EW-CFG_BITS){1'b0}}, slop});
      b    = r2s + sls;
      s4       <= sq_side[RW-1];
      s4_dist  <= ctr_dist;
      s4_zero  <= (ctr_dist == '0);
      s4_coin  <= (ctr_dist < RW'(thresh));
      s4_lo2   <= ds - b;
      s4_hi2   <= ds + b;
      s4_r1    <= r1s;
      s4_crad  <= (r1s > b) ? r1s : b;
    end
  end

  // stage 5: merged extents, radius
  early_t               s5;
  logic                 s5_v, s5_coin, s5_zero, s5_rsat;
  logic [RW-1:0]        s5_dist;
  logic signed [EW-1:0] s5_esum;
  logic [C-2:0]         s5_rad;

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] mn, mx, span, rr;
    if (en) begin
      mn   = (s4_lo2 < -s4_r1) ? s4_lo2 : -s4_r1;
      mx   = (s4_hi2 > s4_r1) ? s4_hi2 : s4_r1;
      span = mx - mn;
      rr   = s4_coin ? s4_crad : (span >>> 1);
      s5      <= s4;
      s5_dist <= s4_dist;
      s5_coin <= s4_coin;
      s5_zero <= s4_zero;
      s5_esum <= mx + mn;
      s5_rsat <= (rr > RAD_MAX);
      s5_rad  <= (rr > RAD_MAX) ? RAD_MAX[C-2:0] : rr[C-2:0];
    end
  end

  // stage 6: partial products of |esum| * |d|
  logic [2:0][DW+H-1:0]  pp_lo;
  logic [2:0][DW+HH-1:0] pp_hi;
  late_t                 s6, s7;
  logic [RW-1:0]         s6_dist, s7_dist;
  logic                  s6_v, s7_v;
  logic [2:0][NW-1:0]    s7_num;

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] em_full;
    logic [EM-1:0]        em;
    if (en) begin
      em_full = (s5_esum < 0) ? -s5_esum : s5_esum;
      em      = em_full[EM-1:0];
      for (int a = 0; a < 3; a++) begin
        pp_lo[a]  <= s5.dmag[a] * em[H-1:0];
        pp_hi[a]  <= s5.dmag[a] * em[EM-1:H];
        s6.neg[a] <= s5.dneg[a] ^ s5_esum[EW-1];
      end
      s6.c1      <= s5.c1;
      s6.kill    <= s5_coin || s5_zero;
      s6.coin    <= s5_coin;
      s6.rad     <= s5_rad;
      s6.rad_sat <= s5_rsat;
      s6_dist    <= s5_dist;
    end
  end

  // stage 7: combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s7_num[a] <= (NW'(pp_hi[a]) << H) + NW'(pp_lo[a]);
      end
      s7      <= s6;
      s7_dist <= s6_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else if (en) begin
      s4_v <= sq_v[RW-1];
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
    end
  end

  // axis offset dividers
  logic [2:0][QW-1:0] quot;
  late_t              dv_side [QW];
  logic [QW-1:0]      dv_v;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tsbm_div #(.DW(VW), .QW(QW)) u_div (
      .clk   (clk),
      .en    (en),
      .numer (s7_num[a]),
      .denom ({s7_dist, 1'b0}),
      .quot  (quot[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (en) begin
      dv_v <= {dv_v[QW-2:0], s7_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s7;
      for (int k = 1; k < QW; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // output stage: apply offsets, clamp
  late_t                     ls;
  logic signed [2:0][C-1:0]  res_c;
  logic [2:0]                csat;

  assign ls = dv_side[QW-1];

  always_comb begin
    logic signed [OW-1:0] off, r;
    for (int a = 0; a < 3; a++) begin
      off = ls.kill ? '0 : (ls.neg[a] ? -$signed(OW'(quot[a])) : $signed(OW'(quot[a])));
      r   = $signed({{(OW-C){ls.c1[a][C-1]}}, ls.c1[a]}) + off;
      csat[a] = 1'b0;
      if (r > CRD_MAX) begin
        res_c[a] = CRD_MAX[C-1:0];
        csat[a]  = 1'b1;
      end else if (r < CRD_MIN) begin
        res_c[a] = CRD_MIN[C-1:0];
        csat[a]  = 1'b1;
      end else begin
        res_c[a] = r[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_center_x <= res_c[0];
      out_center_y <= res_c[1];
      out_center_z <= res_c[2];
      out_radius   <= ls.rad;
      coincident   <= ls.coin;
      saturated    <= ls.rad_sat || (|csat);
    end
  end

endmodule
